>>> rtl/stv_pkg.sv
// stv_pkg: shared constants, codes and types of the sensor timestamp validator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package stv_pkg;

    localparam int NS_W     = 63;
    localparam int TIME_W   = 64;
    localparam int GEN_W    = 64;
    localparam int IDX_W    = 8;
    localparam int CODE_W   = 3;
    localparam int US_MUL_W = 54;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;

    localparam logic [TIME_W-1:0] US_LIMIT = 64'd9223372036854775;
    localparam logic [9:0]        TS_SCALE = 10'd1000;

    localparam logic [IDX_W-1:0] REG_MAX_STALE   = 8'd0;
    localparam logic [IDX_W-1:0] REG_MAX_FUTURE  = 8'd1;
    localparam logic [IDX_W-1:0] REG_RESTART_REG = 8'd2;
    localparam logic [IDX_W-1:0] REG_LOW_EPOCH   = 8'd3;

    localparam logic [NS_W-1:0] RST_MAX_STALE   = 63'd500000000;
    localparam logic [NS_W-1:0] RST_MAX_FUTURE  = 63'd100000000;
    localparam logic [NS_W-1:0] RST_RESTART_REG = 63'd1000000000;
    localparam logic [NS_W-1:0] RST_LOW_EPOCH   = 63'd60000000000;

    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [CODE_W-1:0] {
        EV_ACCEPTED         = 3'd0,
        EV_INVALID          = 3'd1,
        EV_DUPLICATE        = 3'd2,
        EV_SMALL_REGRESSION = 3'd3,
        EV_RESTART          = 3'd4,
        EV_STALE            = 3'd5,
        EV_FUTURE           = 3'd6
    } t_event;

    typedef struct packed {
        logic [NS_W-1:0] max_stale;
        logic [NS_W-1:0] max_future;
        logic [NS_W-1:0] restart_reg;
        logic [NS_W-1:0] low_epoch;
    } t_cfg;

    typedef struct packed {
        logic            clear;
        logic            bad;
        logic            stale;
        logic            future;
        logic [NS_W-1:0] ts;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> rtl/stv_if.sv
// stv_if: valid/ready channel interfaces for input beats, result beats and register writes
// depends on stv_pkg for field widths
`timescale 1ns / 1ps

interface stv_in_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [stv_pkg::TIME_W-1:0]        sample_time_us;
    logic signed [stv_pkg::TIME_W-1:0] current_time_ns;

    modport source (output valid, action, sample_time_us, current_time_ns, input ready);
    modport sink   (input valid, action, sample_time_us, current_time_ns, output ready);
endinterface

interface stv_out_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic [stv_pkg::GEN_W-1:0]  generation;
    logic [stv_pkg::CODE_W-1:0] event_code;

    modport source (output valid, accepted, generation, event_code, input ready);
    modport sink   (input valid, accepted, generation, event_code, output ready);
endinterface

interface stv_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [stv_pkg::IDX_W-1:0]  index;
    logic [stv_pkg::TIME_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/stv_front.sv
// stv_front: two-stage front end, scales the timestamp and classifies each beat
// depends on stv_pkg and stv_in_if; feeds stv_queue
`timescale 1ns / 1ps

module stv_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stv_pkg::t_cfg  i_cfg,
    stv_in_if.sink         i_in,
    input  stv_pkg::t_qstat i_qstat,
    output logic           o_push,
    output stv_pkg::t_qent o_entry
);
    import stv_pkg::*;

    logic              r_s1_valid;
    logic              r_s1_action;
    logic [TIME_W-1:0] r_s1_us;
    logic [TIME_W-1:0] r_s1_now;

    logic              r_s2_valid;
    logic              r_s2_clear;
    logic              r_s2_bad;
    logic [NS_W-1:0]   r_s2_ts;
    logic [NS_W-1:0]   r_s2_now;

    logic              w_s2_adv;
    logic              w_s2_free;
    logic              w_s1_adv;
    logic              w_s1_free;
    logic              w_bad_now;
    logic              w_bad_us;
    logic [TIME_W-1:0] w_prod;
    logic [TIME_W-1:0] w_age;
    logic [TIME_W-1:0] w_lead;
    logic              w_stale;
    logic              w_future;

    assign w_s2_adv  = r_s2_valid && !i_qstat.full;
    assign w_s2_free = !r_s2_valid || w_s2_adv;
    assign w_s1_adv  = r_s1_valid && w_s2_free;
    assign w_s1_free = !r_s1_valid || w_s1_adv;
    assign i_in.ready = w_s1_free;

    // stage 1: range checks and scaling to nanoseconds
    assign w_bad_now = r_s1_now[TIME_W-1] || (r_s1_now == '0);
    assign w_bad_us  = (r_s1_us == '0) || (r_s1_us > US_LIMIT);
    assign w_prod    = {{(TIME_W-US_MUL_W){1'b0}}, r_s1_us[US_MUL_W-1:0]}
                     * {{(TIME_W-10){1'b0}}, TS_SCALE};

    // stage 2: age and lead against the configured limits
    assign w_age    = {1'b0, r_s2_now} - {1'b0, r_s2_ts};
    assign w_lead   = {1'b0, r_s2_ts} - {1'b0, r_s2_now};
    assign w_stale  = !w_age[TIME_W-1] && (w_age[NS_W-1:0] > i_cfg.max_stale);
    assign w_future = !w_lead[TIME_W-1] && (w_lead[NS_W-1:0] > i_cfg.max_future);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= w_s1_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_in.valid) begin
            r_s1_action <= i_in.action;
            r_s1_us     <= i_in.sample_time_us;
            r_s1_now    <= i_in.current_time_ns;
        end
        if (w_s1_adv) begin
            r_s2_clear <= (r_s1_action == ACT_CLEAR);
            r_s2_bad   <= w_bad_now || w_bad_us;
            r_s2_ts    <= w_prod[NS_W-1:0];
            r_s2_now   <= r_s1_now[NS_W-1:0];
        end
    end

    assign o_push         = w_s2_adv;
    assign o_entry.clear  = r_s2_clear;
    assign o_entry.bad    = r_s2_bad;
    assign o_entry.stale  = w_stale;
    assign o_entry.future = w_future;
    assign o_entry.ts     = r_s2_ts;

endmodule

>>> rtl/stv_queue.sv
// stv_queue: short first-in first-out buffer between front and back end
// depends on stv_pkg for the entry type and depth
`timescale 1ns / 1ps

module stv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stv_pkg::t_qent  i_entry,
    input  logic            i_pop,
    output stv_pkg::t_qent  o_entry,
    output stv_pkg::t_qstat o_qstat
);
    import stv_pkg::*;

    t_qent           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_count;
    logic [Q_AW:0]   n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_entry       = r_mem[r_rd];
    assign o_qstat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

>>> rtl/stv_back.sv
// stv_back: history compare, generation update and registered result beat
// depends on stv_pkg and stv_out_if; drains stv_queue
`timescale 1ns / 1ps

module stv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stv_pkg::t_cfg   i_cfg,
    input  stv_pkg::t_qstat i_qstat,
    input  stv_pkg::t_qent  i_entry,
    output logic            o_pop,
    stv_out_if.source       o_out
);
    import stv_pkg::*;

    logic             r_have;
    logic [NS_W-1:0]  r_last;
    logic [GEN_W-1:0] r_gen;
    logic             r_out_valid;
    logic             r_out_acc;
    logic [GEN_W-1:0] r_out_gen;
    t_event           r_out_code;

    logic             n_have;
    logic [NS_W-1:0]  n_last;
    logic [GEN_W-1:0] n_gen;
    logic             n_acc;
    t_event           n_code;

    logic             w_out_free;
    logic             w_not_newer;
    logic             w_equal;
    logic [NS_W-1:0]  w_regr;
    logic             w_restart;
    logic             w_gen_max;
    logic [GEN_W-1:0] w_gen_inc;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_pop      = !i_qstat.empty && (i_entry.clear || w_out_free);

    assign w_not_newer = r_have && (i_entry.ts <= r_last);
    assign w_equal     = (i_entry.ts == r_last);
    assign w_regr      = r_last - i_entry.ts;
    assign w_restart   = (w_regr >= i_cfg.restart_reg) && (r_last > i_cfg.low_epoch)
                      && (i_entry.ts <= i_cfg.low_epoch);
    assign w_gen_max   = &r_gen;
    assign w_gen_inc   = r_gen + 1'b1;

    always_comb begin
        n_have = r_have;
        n_last = r_last;
        n_gen  = r_gen;
        n_acc  = 1'b0;
        n_code = EV_INVALID;
        if (i_entry.clear) begin
            n_have = 1'b0;
            if (!w_gen_max) begin
                n_gen = w_gen_inc;
            end
        end else begin
            priority if (i_entry.bad) begin
                n_code = EV_INVALID;
            end else if (w_not_newer) begin
                priority if (w_equal) begin
                    n_code = EV_DUPLICATE;
                end else if (w_restart && w_gen_max) begin
                    n_code = EV_INVALID;
                end else if (w_restart) begin
                    n_gen  = w_gen_inc;
                    n_last = i_entry.ts;
                    n_acc  = 1'b1;
                    n_code = EV_RESTART;
                end else begin
                    n_code = EV_SMALL_REGRESSION;
                end
            end else if (i_entry.stale) begin
                n_code = EV_STALE;
            end else if (i_entry.future) begin
                n_code = EV_FUTURE;
            end else begin
                n_have = 1'b1;
                n_last = i_entry.ts;
                n_acc  = 1'b1;
                n_code = EV_ACCEPTED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= n_have;
                r_gen  <= n_gen;
            end
            if (o_pop && !i_entry.clear) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_last <= n_last;
        end
        if (o_pop && !i_entry.clear) begin
            r_out_acc  <= n_acc;
            r_out_gen  <= n_gen;
            r_out_code <= n_code;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.accepted   = r_out_acc;
    assign o_out.generation = r_out_gen;
    assign o_out.event_code = r_out_code;

endmodule

>>> rtl/sensor_timestamp_validator.sv
// sensor_timestamp_validator: top level, limit registers, front end, queue and back end
// path: input beat registered in front stage 1 and stage 2, pushed to the queue, then the result register
// throughput: one beat per cycle unless stalled; back end takes one queue entry per cycle
// a clear beat gives no result; the 4-entry queue lets front and back stall apart
// reset: synchronous active low, clears history, generation and pipeline; limits to defaults
`timescale 1ns / 1ps

module sensor_timestamp_validator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stv_in_if.sink    i_in,
    stv_out_if.source o_out,
    stv_cfg_if.sink   i_cfg
);
    import stv_pkg::*;

    t_cfg   r_cfg;
    logic   w_push;
    logic   w_pop;
    t_qent  w_push_entry;
    t_qent  w_head;
    t_qstat w_qstat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_stale   <= RST_MAX_STALE;
            r_cfg.max_future  <= RST_MAX_FUTURE;
            r_cfg.restart_reg <= RST_RESTART_REG;
            r_cfg.low_epoch   <= RST_LOW_EPOCH;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MAX_STALE:   r_cfg.max_stale   <= i_cfg.data[NS_W-1:0];
                REG_MAX_FUTURE:  r_cfg.max_future  <= i_cfg.data[NS_W-1:0];
                REG_RESTART_REG: r_cfg.restart_reg <= i_cfg.data[NS_W-1:0];
                REG_LOW_EPOCH:   r_cfg.low_epoch   <= i_cfg.data[NS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    stv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    stv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head),
        .o_qstat (w_qstat)
    );

    stv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qstat (w_qstat),
        .i_entry (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

>>> rtl/stv_checker.sv
// stv_checker: port-level assertions on the result channel of the validator
// depends on stv_pkg; bound to sensor_timestamp_validator at the end of this file
`timescale 1ns / 1ps

module stv_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_accepted,
    input logic [stv_pkg::GEN_W-1:0]  i_out_generation,
    input logic [stv_pkg::CODE_W-1:0] i_out_event_code
);
    import stv_pkg::*;

    logic             r_seen;
    logic [GEN_W-1:0] r_prev_gen;
    logic             w_fire;

    assign w_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_fire) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_prev_gen <= i_out_generation;
        end
    end

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_generation)
            && $stable(i_out_event_code) && $stable(i_out_accepted))
        else $error("result payload changed while stalled");

    a_gen_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_seen |-> i_out_generation >= r_prev_gen)
        else $error("generation went backwards between result beats");

    a_accept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_accepted == ((i_out_event_code == EV_ACCEPTED)
            || (i_out_event_code == EV_RESTART)))
        else $error("accepted flag disagrees with event code");

endmodule

bind sensor_timestamp_validator stv_checker u_stv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_accepted   (o_out.accepted),
    .i_out_generation (o_out.generation),
    .i_out_event_code (o_out.event_code)
);
